// ===== hdl/wbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wbpm_pkg
// Shared widths, register indexes and types for the masked byte pattern
// matcher.
// ----------------------------------------------------------------------------
package wbpm_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int OFFSET_WIDTH = 32;
  localparam int HIST_DEPTH   = PATTERN_MAX - 1;
  localparam int WIN_IDX_W    = $clog2(PATTERN_MAX);

  localparam int DATA_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CARE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int MATCH_W    = 32;
  localparam int PATTERN_W  = DATA_W * PATTERN_MAX;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd3;

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

  typedef logic [DATA_W-1:0] data_t;
  typedef data_t [PATTERN_MAX-1:0] win_t;   // index 0 is the newest byte
  typedef data_t [HIST_DEPTH-1:0] hist_t;

  typedef struct packed {
    logic [PATTERN_W-1:0]   pattern;
    logic [PATTERN_MAX-1:0] care;
    logic [LEN_W-1:0]       len;
  } wbpm_cfg_t;

endpackage

// ===== hdl/wbpm_window_cmp.sv =====
// ----------------------------------------------------------------------------
// wbpm_window_cmp
// Masked compare of the current byte window against the configured pattern.
// ----------------------------------------------------------------------------
module wbpm_window_cmp
  import wbpm_pkg::*;
(
  input  win_t      win,
  input  wbpm_cfg_t cfg,
  output logic      hit
);

  logic [PATTERN_MAX-1:0] care_eff;
  logic [PATTERN_MAX-1:0] byte_ok;
  logic [WIN_IDX_W-1:0]   idx [PATTERN_MAX];

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      care_eff[i] = cfg.care[i] && (LEN_W'(i) < cfg.len);
      // pattern byte i lines up with the byte (len-1-i) positions back
      idx[i]      = WIN_IDX_W'(cfg.len - LEN_W'(i) - LEN_W'(1));
      byte_ok[i]  = !care_eff[i] || (win[idx[i]] == cfg.pattern[DATA_W*i +: DATA_W]);
    end
  end

  // a pattern with no concrete byte never matches
  assign hit = (|care_eff) && (&byte_ok);

endmodule

// ===== hdl/wildcard_byte_pattern_matcher_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher_core
// Reports the start offset of every masked pattern match in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one buffer byte per word plus a
//   last-byte flag. The result channel (out_valid/out_ready) carries the start
//   offset of a match; a word yields at most one result, on the word that
//   brings the match's final byte, so overlapping matches come out in order.
//   A match shows on out_valid in the cycle after its word is accepted. The
//   pattern compare is a single parallel masked compare over the byte
//   history, between the input handshake and the output register. One word
//   is taken every cycle, but in_ready drops while a result waits on a
//   stalled receiver; words with no result leave the output register empty.
//   The last-byte flag clears history, count and offset after that word.
//   Config writes (cfg_wr_en/cfg_index/cfg_wdata) take effect on the next
//   word; users make them while the block is idle (not enforced). Synchronous
//   reset clears the config registers, history, offset and the output valid.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher_core
  import wbpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_W-1:0]     in_data_byte,
  input  logic                  in_last_byte,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MATCH_W-1:0]    out_match_start
);

  logic [CFG_DATA_W-1:0]   pat_lo_r,  pat_lo_nxt;
  logic [CFG_DATA_W-1:0]   pat_hi_r,  pat_hi_nxt;
  logic [CARE_W-1:0]       care_r,    care_nxt;
  logic [LEN_W-1:0]        len_r,     len_nxt;

  hist_t                   hist_r,    hist_nxt;
  logic [LEN_W-1:0]        seen_r,    seen_nxt;
  logic [OFFSET_WIDTH-1:0] pos_r,     pos_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [MATCH_W-1:0]      start_r,     start_nxt;

  wbpm_cfg_t               cfg;
  win_t                    win;
  logic                    cmp_hit;
  logic                    accept;
  logic                    len_ok;
  logic                    seen_ok;
  logic                    hit;
  logic [OFFSET_WIDTH-1:0] start_full;

  assign cfg.pattern = PATTERN_W'({pat_hi_r, pat_lo_r});
  assign cfg.care    = PATTERN_MAX'(care_r);
  assign cfg.len     = len_r;

  always_comb begin
    win[0] = in_data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win[k] = hist_r[k-1];
    end
  end

  wbpm_window_cmp u_cmp (
    .win (win),
    .cfg (cfg),
    .hit (cmp_hit)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign len_ok  = (len_r != '0) && (len_r <= LEN_W'(PATTERN_MAX));
  assign seen_ok = ({1'b0, seen_r} + (LEN_W+1)'(1)) >= {1'b0, len_r};
  assign hit     = cmp_hit && len_ok && seen_ok && (pos_r != OFFSET_MAX);

  assign start_full = pos_r - OFFSET_WIDTH'(len_r) + OFFSET_WIDTH'(1);

  // config registers
  always_comb begin
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    care_nxt   = care_r;
    len_nxt    = len_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pat_lo_nxt = cfg_wdata;
        CFG_PATTERN_HIGH:   pat_hi_nxt = cfg_wdata;
        CFG_CARE_MASK:      care_nxt   = cfg_wdata[CARE_W-1:0];
        CFG_PATTERN_LENGTH: len_nxt    = cfg_wdata[LEN_W-1:0];
        default:            ;
      endcase
    end
  end

  // history, byte count and offset
  always_comb begin
    hist_nxt = hist_r;
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    if (accept) begin
      if (in_last_byte) begin
        hist_nxt = '0;
        seen_nxt = '0;
        pos_nxt  = '0;
      end else begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
          hist_nxt[k] = hist_r[k-1];
        end
        hist_nxt[0] = in_data_byte;
        if (seen_r < LEN_W'(PATTERN_MAX)) begin
          seen_nxt = seen_r + LEN_W'(1);
        end
        if (pos_r != OFFSET_MAX) begin
          pos_nxt = pos_r + OFFSET_WIDTH'(1);
        end
      end
    end
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    start_nxt     = start_r;
    if (accept) begin
      out_valid_nxt = hit;
      start_nxt     = MATCH_W'(start_full);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      care_r      <= '0;
      len_r       <= '0;
      hist_r      <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pat_lo_r    <= pat_lo_nxt;
      pat_hi_r    <= pat_hi_nxt;
      care_r      <= care_nxt;
      len_r       <= len_nxt;
      hist_r      <= hist_nxt;
      seen_r      <= seen_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = start_r;

endmodule

// ===== hdl/wbpm_checker.sv =====
// ----------------------------------------------------------------------------
// wbpm_checker
// Port-level checks for the masked byte pattern matcher.
// ----------------------------------------------------------------------------
module wbpm_checker
  import wbpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [MATCH_W-1:0] out_match_start
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_start))
    else $error("result word changed while stalled");

  // input side open whenever the output register can drain
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("in_ready low with output register free");

  // a new result only follows an accepted input word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without input word");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind wildcard_byte_pattern_matcher_core wbpm_checker u_wbpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_match_start (out_match_start)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for wildcard_byte_pattern_matcher_core. Streams buffer bytes
// through the input channel under several pattern configurations and idle
// patterns. A behavioral predictor of the masked window compare tracks
// history, fill count and offset, and every match start coming out is checked
// in order against the predicted starts.
// ----------------------------------------------------------------------------
module tb_top;
  import wbpm_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int SETTLE_CYCLES   = 4;     // output register plus margin
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 180;
  localparam int MAX_PRINTED     = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [DATA_W-1:0]     in_data_byte;
  logic                  in_last_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [MATCH_W-1:0]    out_match_start;

  // predictor state and shadow of the config registers
  data_t                   recent_bytes [HIST_DEPTH];   // newest first
  int unsigned             fill_count;
  logic [OFFSET_WIDTH-1:0] next_offset;
  logic [63:0]             pat_lo;
  logic [63:0]             pat_hi;
  logic [CARE_W-1:0]       care_bits;
  logic [LEN_W-1:0]        pat_len;

  logic [MATCH_W-1:0] pending_starts [$];
  logic [MATCH_W-1:0] want_start;
  int                 err_cnt;
  int                 gap_pct;
  int                 stall_pct;
  int                 quiet_cycles;

  wildcard_byte_pattern_matcher_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Masked compare of the window ending at the newest byte, then state update.
  task automatic predict_match_start(input data_t b, input logic last);
    logic [127:0] pat;
    data_t        seen;
    int           ago;
    bit           hit;
    pat = {pat_hi, pat_lo};
    hit = 0;
    if (next_offset != OFFSET_MAX && pat_len != 0 && pat_len <= PATTERN_MAX &&
        (care_bits & ((32'd1 << pat_len) - 32'd1)) != 0 && fill_count + 1 >= pat_len) begin
      hit = 1;
      for (int i = 0; i < pat_len; i++) begin
        ago  = pat_len - 1 - i;
        seen = (ago == 0) ? b : recent_bytes[ago - 1];
        if (care_bits[i] && seen != pat[8*i +: 8]) hit = 0;
      end
    end
    if (hit) begin
      pending_starts.insert(pending_starts.size(),
          MATCH_W'(next_offset - OFFSET_WIDTH'(pat_len) + OFFSET_WIDTH'(1)));
    end
    if (last) begin
      foreach (recent_bytes[k]) recent_bytes[k] = '0;
      fill_count  = 0;
      next_offset = '0;
    end else begin
      for (int k = HIST_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
      recent_bytes[0] = b;
      if (fill_count < PATTERN_MAX) fill_count++;
      if (next_offset != OFFSET_MAX) next_offset++;
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 47; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 47; end
      default: begin gap_pct = 28; stall_pct = 28; end
    endcase
  endtask

  task automatic send_word(input data_t b, input logic last);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_match_start(b, last);
  endtask

  // Waits on a clock edge before checking the queue, so in_valid is never driven twice a step.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_starts.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] care_w, input logic [63:0] len_w);
    hold_until_drained();
    // margin after the drain before the config writes
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PATTERN_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_PATTERN_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_CARE_MASK;
    cfg_wdata <= care_w;
    @(posedge clk);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_wdata <= len_w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pat_lo    = lo;
    pat_hi    = hi;
    care_bits = care_w[CARE_W-1:0];
    pat_len   = len_w[LEN_W-1:0];
  endtask

  function automatic data_t pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      3: return 8'hA5;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Registers still at reset: length zero, nothing may match.
  task automatic test_reset_state();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_full_width_pattern();
    logic [127:0] pat;
    for (int i = 0; i < PATTERN_MAX; i++) pat[8*i +: 8] = i[0] ? 8'hFF : 8'h00;
    load_config(pat[63:0], pat[127:64], 64'hFFFF, 64'd16);
    for (int i = 0; i < PATTERN_MAX; i++) send_word(pat[8*i +: 8], i == PATTERN_MAX - 1);
  endtask

  // Byte 1 is a wildcard, high care bits lie beyond the length. The first
  // byte alone is a short buffer; the next two give overlapping matches.
  task automatic test_overlap_short_buffer();
    load_config(64'h3CA5, 64'h0, 64'hFF01, 64'd2);
    send_word(8'hA5, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'hA5, 1'b1);
  endtask

  task automatic test_no_concrete_byte();
    load_config(64'h0, 64'h0, 64'hFFF8, 64'd3);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_length_too_large();
    load_config(64'h0, 64'h0, 64'hFFFF, 64'd17);
    send_word(8'h00, 1'b0);
    load_config(64'h0, 64'h0, 64'hFFFF, 64'd31);
    send_word(8'h00, 1'b1);
  endtask

  // Mostly pattern instances with random wildcard content, some broken,
  // mixed with noise bytes; buffers end at random.
  task automatic test_random_stream();
    logic [127:0]      pat;
    logic [CARE_W-1:0] care;
    logic [LEN_W-1:0]  len;
    logic [63:0]       junk;
    data_t             b;
    int                n;
    int                bad;
    bit                held;
    held = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       len = LEN_W'(PATTERN_MAX);
        6:       len = LEN_W'($urandom_range(9, PATTERN_MAX - 1));
        default: len = LEN_W'($urandom_range(1, 8));
      endcase
      pat = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < len; i++) pat[8*i +: 8] = pick_byte();
      care = (p % 3 == 0) ? '1 : CARE_W'($urandom);
      if ((care & ((32'd1 << len) - 32'd1)) == 0) care[0] = 1'b1;
      junk = p[0] ? {$urandom, $urandom} : '0;
      load_config(pat[63:0], pat[127:64], {junk[63:CARE_W], care},
                  {junk[63:LEN_W], len});
      set_idling(p % 4);
      n = 0;
      while (n < WORDS_PER_PHASE) begin
        if (p == 2 && !held && n >= WORDS_PER_PHASE / 2) begin
          hold_until_drained();
          held = 1;
        end
        if ($urandom_range(99) < 55) begin
          bad = ($urandom_range(99) < 15) ? $urandom_range(0, len - 1) : -1;
          for (int i = 0; i < len; i++) begin
            if (i == bad) b = ~pat[8*i +: 8];
            else if (care[i]) b = pat[8*i +: 8];
            else b = pick_byte();
            send_word(b, $urandom_range(49) == 0);
            n++;
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_word(pick_byte(), $urandom_range(49) == 0);
            n++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_starts.size() == 0) begin
        report_mismatch($sformatf("match_start %0d with none expected", out_match_start));
      end else begin
        want_start = pending_starts.pop_front();
        if (out_match_start !== want_start)
          report_mismatch($sformatf("match_start %0d, expected %0d",
                                    out_match_start, want_start));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_PATTERN_LOW;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    out_ready    = 1'b1;
    quiet_cycles = 0;
    err_cnt      = 0;
    foreach (recent_bytes[k]) recent_bytes[k] = '0;
    fill_count   = 0;
    next_offset  = '0;
    pat_lo       = '0;
    pat_hi       = '0;
    care_bits    = '0;
    pat_len      = '0;
    set_idling(0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_full_width_pattern();
    test_overlap_short_buffer();
    test_no_concrete_byte();
    test_length_too_large();
    test_random_stream();

    hold_until_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (pending_starts.size() != 0)
      report_mismatch($sformatf("%0d match starts never came", pending_starts.size()));
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
